[hdl/lru_key_list_core_macros.svh]
// Assertion macros shared by the checker of the LRU key list.
// Depends on nothing; each macro takes a label, clock, active-low reset and the property terms.
`ifndef LRU_KEY_LIST_CORE_MACROS_SVH
`define LRU_KEY_LIST_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define LKL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lkl: implication check failed");

// next-cycle implication, disabled while reset is low
`define LKL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lkl: next-cycle check failed");

`endif

[hdl/lkl_pkg.sv]
// Shared constants, codes and types of the LRU key list.
// No dependencies; used by the interfaces, the cell, the top level and the checker.
package lkl_pkg;

    localparam int ENTRIES  = 16;
    localparam int KEY_BITS = 32;

    // port field widths
    localparam int OP_W   = 2;
    localparam int KEY_W  = 32;
    localparam int ST_W   = 3;
    localparam int FPOS_W = 4;
    localparam int TOT_W  = 5;
    localparam int CAP_W  = 5;

    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CAP_W > CNT_W) ? CAP_W : CNT_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_TOUCH  = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    localparam logic [ST_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [ST_W-1:0] ST_EVICTED   = 3'd1;
    localparam logic [ST_W-1:0] ST_MOVED     = 3'd2;
    localparam logic [ST_W-1:0] ST_REMOVED   = 3'd3;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd4;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic cmp;     // compare cycle: latch the match flag
        logic key_nz;  // incoming key is not zero
        logic upd;     // shift cycle: rewrite the row
        logic front;   // hit on add or touch: move to front
        logic insert;  // miss on add: insert at the front
        logic grow;    // insert without eviction
        logic remove;  // hit on remove: close the gap
    } t_cell_ctrl;

endpackage

[hdl/lkl_item_if.sv]
// Input channel of the LRU key list: valid/ready handshake with op and key.
// Depends on lkl_pkg for the field widths.
interface lkl_item_if;
    logic                       valid;
    logic                       ready;
    logic [lkl_pkg::OP_W-1:0]   op;
    logic [lkl_pkg::KEY_W-1:0]  key;

    modport source (output valid, op, key, input ready);
    modport sink   (input valid, op, key, output ready);
endinterface

[hdl/lkl_result_if.sv]
// Result channel of the LRU key list: valid/ready handshake with the result fields.
// Depends on lkl_pkg for the field widths.
interface lkl_result_if;
    logic                        valid;
    logic                        ready;
    logic [lkl_pkg::ST_W-1:0]    status;
    logic [lkl_pkg::KEY_W-1:0]   evicted_key;
    logic [lkl_pkg::FPOS_W-1:0]  found_position;
    logic [lkl_pkg::TOT_W-1:0]   entry_total;

    modport source (output valid, status, evicted_key, found_position, entry_total,
                    input ready);
    modport sink   (input valid, status, evicted_key, found_position, entry_total,
                    output ready);
endinterface

[hdl/lkl_cell.sv]
// One position of the recency row: holds a key, compares it, shifts with its neighbours.
// Depends on lkl_pkg for the key width and the control struct.
module lkl_cell (
    input  logic                           i_clk,
    input  lkl_pkg::t_cell_ctrl            i_ctrl,
    input  logic [lkl_pkg::KEY_BITS-1:0]   i_cmp_key,
    input  logic [lkl_pkg::KEY_BITS-1:0]   i_left_key,
    input  logic [lkl_pkg::KEY_BITS-1:0]   i_right_key,
    input  logic                           i_live,
    input  logic                           i_live_left,
    input  logic                           i_live_right,
    input  logic                           i_seen,
    input  logic [lkl_pkg::KEY_BITS-1:0]   i_pick,
    output logic                           o_seen,
    output logic [lkl_pkg::KEY_BITS-1:0]   o_pick,
    output logic [lkl_pkg::KEY_BITS-1:0]   o_key
);

    logic [lkl_pkg::KEY_BITS-1:0] r_key;
    logic [lkl_pkg::KEY_BITS-1:0] n_key;
    logic                         r_match;
    logic                         n_match;

    assign o_seen = i_seen | r_match;
    assign o_key  = r_key;
    // the last live cell offers its key for eviction
    assign o_pick = i_pick | ((i_live && !i_live_right) ? r_key : '0);

    always_comb begin
        n_match = r_match;
        if (i_ctrl.cmp) begin
            n_match = i_live && i_ctrl.key_nz && (r_key == i_cmp_key);
        end
    end

    always_comb begin
        n_key = r_key;
        if (i_ctrl.upd) begin
            if (i_ctrl.front && !i_seen) begin
                n_key = i_left_key;
            end else if (i_ctrl.insert && (i_ctrl.grow ? i_live_left : i_live)) begin
                n_key = i_left_key;
            end else if (i_ctrl.remove && o_seen) begin
                n_key = i_right_key;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_match <= n_match;
    end

endmodule

[hdl/lru_key_list_core.sv]
// Top level of the LRU key list: the row of lkl_cell instances, the count and the result register.
// Depends on lkl_pkg, lkl_item_if, lkl_result_if and lkl_cell.
//
// Keeps up to ENTRIES keys ordered from most to least recently used. At the transfer of an
// item every cell compares its key with the incoming one and latches a match flag; then,
// once the output register is free, the row shifts one place (towards the back for
// move-to-front and insert, towards the front for remove) and the result is loaded into
// the output register. No new item is taken until that shift is done; the shift waits
// while the previous result has not been taken. A capacity write is registered and
// applies to every later shift; 0 acts as 1 and values above ENTRIES act as ENTRIES.
module lru_key_list_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [lkl_pkg::CAP_W-1:0]   i_cfg_data,
    lkl_item_if.sink                    i_item,
    lkl_result_if.source                o_result
);

    localparam int N = lkl_pkg::ENTRIES;
    localparam int KB = lkl_pkg::KEY_BITS;

    lkl_pkg::t_state r_state;
    lkl_pkg::t_state n_state;

    logic [lkl_pkg::CAP_W-1:0]  r_cap;
    logic [lkl_pkg::CNT_W-1:0]  r_count;
    logic [lkl_pkg::CNT_W-1:0]  n_count;
    logic [lkl_pkg::OP_W-1:0]   r_op;
    logic [KB-1:0]              r_key;

    logic                          r_out_valid;
    logic [lkl_pkg::ST_W-1:0]      r_status;
    logic [lkl_pkg::KEY_W-1:0]     r_evicted;
    logic [lkl_pkg::FPOS_W-1:0]    r_fpos;
    logic [lkl_pkg::TOT_W-1:0]     r_total;
    logic [lkl_pkg::ST_W-1:0]      n_status;
    logic [lkl_pkg::KEY_W-1:0]     n_evicted;
    logic [lkl_pkg::FPOS_W-1:0]    n_fpos;

    logic w_accept;
    logic w_out_free;
    logic w_upd;
    logic w_hit;
    logic w_full;
    logic [lkl_pkg::CMP_W-1:0] w_cap_ext;
    logic [lkl_pkg::CMP_W-1:0] w_eff_cap;
    logic [KB-1:0] w_in_key;
    logic [lkl_pkg::FPOS_W-1:0] w_pos;

    logic [N-1:0]  w_live;
    logic [N:0]    w_seen;
    logic [KB-1:0] w_pick [N+1];
    logic [KB-1:0] w_cell_key [N];
    lkl_pkg::t_cell_ctrl w_ctrl;

    assign w_in_key   = KB'(i_item.key);
    assign w_accept   = i_item.valid && i_item.ready;
    assign w_out_free = !r_out_valid || o_result.ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lkl_pkg::S_IDLE: begin
                if (w_accept) n_state = lkl_pkg::S_EXEC;
            end
            lkl_pkg::S_EXEC: begin
                if (w_out_free) n_state = lkl_pkg::S_IDLE;
            end
            default: n_state = lkl_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        i_item.ready = 1'b0;
        w_upd        = 1'b0;
        case (r_state)
            lkl_pkg::S_IDLE: i_item.ready = 1'b1;
            lkl_pkg::S_EXEC: w_upd = w_out_free;
            default: begin
                i_item.ready = 1'b0;
                w_upd        = 1'b0;
            end
        endcase
    end

    // effective capacity and fullness
    assign w_cap_ext = lkl_pkg::CMP_W'(r_cap);
    always_comb begin
        if (w_cap_ext == '0) begin
            w_eff_cap = lkl_pkg::CMP_W'(1);
        end else if (w_cap_ext > lkl_pkg::CMP_W'(N)) begin
            w_eff_cap = lkl_pkg::CMP_W'(N);
        end else begin
            w_eff_cap = w_cap_ext;
        end
    end
    assign w_full = lkl_pkg::CMP_W'(r_count) >= w_eff_cap;

    assign w_hit = w_seen[N];

    always_comb begin
        w_ctrl        = '0;
        w_ctrl.cmp    = w_accept;
        w_ctrl.key_nz = (w_in_key != '0);
        w_ctrl.upd    = w_upd;
        w_ctrl.front  = ((r_op == lkl_pkg::OP_ADD) || (r_op == lkl_pkg::OP_TOUCH)) && w_hit;
        w_ctrl.insert = (r_op == lkl_pkg::OP_ADD) && !w_hit;
        w_ctrl.grow   = !w_full;
        w_ctrl.remove = (r_op == lkl_pkg::OP_REMOVE) && w_hit;
    end

    assign w_seen[0] = 1'b0;
    assign w_pick[0] = '0;

    for (genvar g = 0; g < N; g++) begin : g_cell
        logic [KB-1:0] w_left;
        logic [KB-1:0] w_right;
        logic          w_live_left;
        logic          w_live_right;

        assign w_live[g] = lkl_pkg::CNT_W'(g) < r_count;

        if (g == 0) begin : g_first
            // the incoming key enters from the left of the front cell
            assign w_left      = r_key;
            assign w_live_left = 1'b1;
        end else begin : g_inner_l
            assign w_left      = w_cell_key[g-1];
            assign w_live_left = w_live[g-1];
        end

        if (g == N - 1) begin : g_last
            assign w_right      = '0;
            assign w_live_right = 1'b0;
        end else begin : g_inner_r
            assign w_right      = w_cell_key[g+1];
            assign w_live_right = w_live[g+1];
        end

        lkl_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_cmp_key    (w_in_key),
            .i_left_key   (w_left),
            .i_right_key  (w_right),
            .i_live       (w_live[g]),
            .i_live_left  (w_live_left),
            .i_live_right (w_live_right),
            .i_seen       (w_seen[g]),
            .i_pick       (w_pick[g]),
            .o_seen       (w_seen[g+1]),
            .o_pick       (w_pick[g+1]),
            .o_key        (w_cell_key[g])
        );
    end

    // encode the first matching position
    always_comb begin
        w_pos = '0;
        for (int i = 0; i < N; i++) begin
            if (w_seen[i+1] && !w_seen[i]) w_pos = w_pos | lkl_pkg::FPOS_W'(i);
        end
    end

    always_comb begin
        case (r_op)
            lkl_pkg::OP_ADD: begin
                if (w_hit) n_status = lkl_pkg::ST_MOVED;
                else if (w_full) n_status = lkl_pkg::ST_EVICTED;
                else n_status = lkl_pkg::ST_INSERTED;
            end
            lkl_pkg::OP_TOUCH:  n_status = w_hit ? lkl_pkg::ST_MOVED : lkl_pkg::ST_NOT_FOUND;
            lkl_pkg::OP_REMOVE: n_status = w_hit ? lkl_pkg::ST_REMOVED : lkl_pkg::ST_NOT_FOUND;
            default:            n_status = lkl_pkg::ST_NOT_FOUND;
        endcase
    end

    always_comb begin
        n_evicted = '0;
        n_fpos    = '0;
        n_count   = r_count;
        if (w_ctrl.front) begin
            n_fpos = w_pos;
        end else if (w_ctrl.insert) begin
            if (w_full) n_evicted = lkl_pkg::KEY_W'(w_pick[N]);
            else n_count = r_count + lkl_pkg::CNT_W'(1);
        end else if (w_ctrl.remove) begin
            n_fpos    = w_pos;
            n_evicted = lkl_pkg::KEY_W'(r_key);
            n_count   = r_count - lkl_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lkl_pkg::S_IDLE;
            r_cap       <= lkl_pkg::CAP_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_cap <= i_cfg_data;
            if (w_upd) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: hold the item during the shift cycle, load the result at its end
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= i_item.op;
            r_key <= w_in_key;
        end
        if (w_upd) begin
            r_status  <= n_status;
            r_evicted <= n_evicted;
            r_fpos    <= n_fpos;
            r_total   <= lkl_pkg::TOT_W'(n_count);
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.status         = r_status;
    assign o_result.evicted_key    = r_evicted;
    assign o_result.found_position = r_fpos;
    assign o_result.entry_total    = r_total;

endmodule

[hdl/lkl_chk.sv]
// Port-level checker of the LRU key list and its bind to the top level.
// Depends on lkl_pkg and lru_key_list_core_macros.svh.
`include "lru_key_list_core_macros.svh"

module lkl_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [lkl_pkg::ST_W-1:0]      i_status,
    input logic [lkl_pkg::KEY_W-1:0]     i_evicted_key,
    input logic [lkl_pkg::FPOS_W-1:0]    i_found_position,
    input logic [lkl_pkg::TOT_W-1:0]     i_entry_total
);

    // an item occupies the block for its shift cycle
    `LKL_ASSERT_NXT(a_no_back_to_back, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

    // a stalled result stays valid and keeps its status, evicted key and total
    `LKL_ASSERT_NXT(a_result_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_status) && $stable(i_evicted_key) && $stable(i_entry_total))

    `LKL_ASSERT_IMP(a_total_bound, i_clk, i_rst_n, i_out_valid, i_entry_total <= lkl_pkg::TOT_W'(lkl_pkg::ENTRIES))

    // a dropped key is reported only on eviction or removal
    `LKL_ASSERT_IMP(a_drop_zero, i_clk, i_rst_n, i_out_valid && i_status != lkl_pkg::ST_EVICTED && i_status != lkl_pkg::ST_REMOVED, i_evicted_key == '0)

    `LKL_ASSERT_IMP(a_pos_zero, i_clk, i_rst_n, i_out_valid && i_status != lkl_pkg::ST_MOVED && i_status != lkl_pkg::ST_REMOVED, i_found_position == '0)

endmodule

bind lru_key_list_core lkl_chk u_lkl_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_item.valid),
    .i_in_ready       (i_item.ready),
    .i_out_valid      (o_result.valid),
    .i_out_ready      (o_result.ready),
    .i_status         (o_result.status),
    .i_evicted_key    (o_result.evicted_key),
    .i_found_position (o_result.found_position),
    .i_entry_total    (o_result.entry_total)
);
